// ----- rtl/mpsm_pkg.sv -----
// ----------------------------------------------------------------------------
// mpsm_pkg
// shared constants, op and status codes for the multi-pattern string matcher
// ----------------------------------------------------------------------------
package mpsm_pkg;

	localparam int ALPHABET_SIZE_DEF = 26;
	localparam int MAX_PATTERNS_DEF  = 16;
	localparam int MAX_NODES_DEF     = 1024;

	localparam int OP_W     = 3;
	localparam int SYMBOL_W = 5;
	localparam int IDX_W    = 4;
	localparam int POS_W    = 32;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
	localparam logic [OP_W-1:0] OP_END   = 3'd2;
	localparam logic [OP_W-1:0] OP_BUILD = 3'd3;
	localparam logic [OP_W-1:0] OP_TEXT  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NODE_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PAT_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

	function automatic int addr_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

// ----- rtl/multi_pattern_string_matcher.sv -----
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher
// aho-corasick automaton: trie insert, breadth-first link build, text walk
// ----------------------------------------------------------------------------
//  channel | signals                                           | direction
//  input   | in_valid in_ready op symbol                       | into block
//  output  | out_valid out_ready match_valid pattern_index     | out of block
//          | start_position status last                        |
//
//  one transaction at a time; in_ready only in the idle state
//  pattern letter: row read, decide, respond; end op: end set read, write, respond;
//  text letter: failure walk, end set read, bit scan, a result per match or one if none
//  link build: per node a pop, row read, slot scan; per child a walk and end merge
//  after reset and on clear: a pass over all MAX_NODES addresses zeroes the trie memories
//  a stalled output holds the sequencer in its emitting state
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher #(
	parameter int ALPHABET_SIZE = mpsm_pkg::ALPHABET_SIZE_DEF,
	parameter int MAX_PATTERNS  = mpsm_pkg::MAX_PATTERNS_DEF,
	parameter int MAX_NODES     = mpsm_pkg::MAX_NODES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mpsm_pkg::OP_W-1:0]     op,
	input  logic [mpsm_pkg::SYMBOL_W-1:0] symbol,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          match_valid,
	output logic [mpsm_pkg::IDX_W-1:0]    pattern_index,
	output logic [mpsm_pkg::POS_W-1:0]    start_position,
	output logic [mpsm_pkg::STATUS_W-1:0] status,
	output logic                          last
);

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int SYM_W  = $clog2(ALPHABET_SIZE);
	localparam int ROW_W  = ALPHABET_SIZE * NODE_W;
	localparam int PI_W   = mpsm_pkg::addr_w(MAX_PATTERNS);
	localparam int PC_W   = $clog2(MAX_PATTERNS + 1);
	localparam int LEN_W  = NODE_W + 1;
	localparam int QP_W   = NODE_W + 1;
	localparam int POS_W  = mpsm_pkg::POS_W;

	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_RESP   = 5'd2;
	localparam logic [4:0] S_I_RD   = 5'd3;
	localparam logic [4:0] S_I_DEC  = 5'd4;
	localparam logic [4:0] S_E_RD   = 5'd5;
	localparam logic [4:0] S_E_WR   = 5'd6;
	localparam logic [4:0] S_B_POP  = 5'd7;
	localparam logic [4:0] S_B_CUR  = 5'd8;
	localparam logic [4:0] S_B_ROW  = 5'd9;
	localparam logic [4:0] S_B_CH   = 5'd10;
	localparam logic [4:0] S_B_EP1  = 5'd11;
	localparam logic [4:0] S_B_EP2  = 5'd12;
	localparam logic [4:0] S_B_EP3  = 5'd13;
	localparam logic [4:0] S_W_RD   = 5'd14;
	localparam logic [4:0] S_W_CHK  = 5'd15;
	localparam logic [4:0] S_T_EPRD = 5'd16;
	localparam logic [4:0] S_T_SET  = 5'd17;
	localparam logic [4:0] S_T_SCAN = 5'd18;
	localparam logic [4:0] S_T_EMIT = 5'd19;
	localparam logic [4:0] S_T_NONE = 5'd20;

	logic [4:0]                    state_q;
	logic [NODE_W-1:0]             clr_addr_q;
	logic                          clr_resp_q;
	logic [NODE_W-1:0]             node_count_q;
	logic [PC_W-1:0]               pattern_count_q;
	logic [NODE_W-1:0]             insert_node_q;
	logic [LEN_W-1:0]              insert_len_q;
	logic [NODE_W-1:0]             match_node_q;
	logic [POS_W-1:0]              text_pos_q;
	logic [POS_W-1:0]              pos_q;
	logic [mpsm_pkg::STATUS_W-1:0] status_q;
	logic [QP_W-1:0]               head_q;
	logic [QP_W-1:0]               tail_q;
	logic [NODE_W-1:0]             cur_q;
	logic [ROW_W-1:0]              cur_row_q;
	logic [NODE_W-1:0]             cur_fail_q;
	logic [SYM_W-1:0]              c_q;
	logic [NODE_W-1:0]             w_node_q;
	logic [SYM_W-1:0]              w_sym_q;
	logic                          w_ret_q;
	logic [NODE_W-1:0]             nx_q;
	logic [NODE_W-1:0]             lk_q;
	logic [MAX_PATTERNS-1:0]       ep_lk_q;
	logic [MAX_PATTERNS-1:0]       ws_q;
	logic [PI_W-1:0]               pi_q;

	logic                          out_valid_q;
	logic                          match_valid_q;
	logic [mpsm_pkg::IDX_W-1:0]    pattern_index_q;
	logic [POS_W-1:0]              start_position_q;
	logic [mpsm_pkg::STATUS_W-1:0] status_out_q;
	logic                          last_q;

	logic [ROW_W-1:0]        child_rd;
	logic [ROW_W-1:0]        new_row;
	logic [NODE_W-1:0]       fail_rd;
	logic [MAX_PATTERNS-1:0] end_rd;
	logic [NODE_W-1:0]       q_rd;
	logic [LEN_W-1:0]        len_rd;

	logic                    c_we;
	logic [NODE_W-1:0]       c_waddr;
	logic [ROW_W-1:0]        c_wdata;
	logic [NODE_W-1:0]       c_raddr;
	logic                    f_we;
	logic [NODE_W-1:0]       f_waddr;
	logic [NODE_W-1:0]       f_wdata;
	logic [NODE_W-1:0]       f_raddr;
	logic                    e_we;
	logic [NODE_W-1:0]       e_waddr;
	logic [MAX_PATTERNS-1:0] e_wdata;
	logic [NODE_W-1:0]       e_raddr;
	logic                    q_we;
	logic [NODE_W-1:0]       q_waddr;
	logic [NODE_W-1:0]       q_wdata;
	logic                    l_we;

	logic                          accept;
	logic                          sym_ok;
	logic [SYM_W-1:0]              sym_idx;
	logic [NODE_W-1:0]             row_sel;
	logic [NODE_W-1:0]             cur_sel;
	logic                          node_full;
	logic [MAX_PATTERNS-1:0]       pi_bit;
	logic [MAX_PATTERNS-1:0]       pc_bit;
	logic                          can_put;
	logic                          put;
	logic                          p_match;
	logic [mpsm_pkg::IDX_W-1:0]    p_idx;
	logic [POS_W-1:0]              p_start;
	logic [mpsm_pkg::STATUS_W-1:0] p_status;
	logic                          p_last;
	logic                          c_last;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign sym_ok    = (32'(symbol) < 32'(ALPHABET_SIZE));
	assign sym_idx   = SYM_W'(symbol);
	assign row_sel   = child_rd[w_sym_q*NODE_W +: NODE_W];
	assign cur_sel   = cur_row_q[c_q*NODE_W +: NODE_W];
	assign node_full = (node_count_q == NODE_W'(MAX_NODES - 1));
	assign pi_bit    = MAX_PATTERNS'(1) << pi_q;
	assign pc_bit    = MAX_PATTERNS'(1) << pattern_count_q;
	assign can_put   = !out_valid_q || out_ready;
	assign c_last    = (c_q == SYM_W'(ALPHABET_SIZE - 1));

	// result selection
	always_comb begin
		put      = 1'b0;
		p_match  = 1'b0;
		p_idx    = '0;
		p_start  = '0;
		p_status = mpsm_pkg::ST_OK;
		p_last   = 1'b1;
		unique case (state_q)
			S_RESP: begin
				put      = can_put;
				p_status = status_q;
			end
			S_T_NONE: begin
				put = can_put;
			end
			S_T_EMIT: begin
				put     = can_put;
				p_match = 1'b1;
				p_idx   = mpsm_pkg::IDX_W'(pi_q);
				p_start = pos_q - POS_W'(len_rd) + POS_W'(1);
				p_last  = ((ws_q & ~pi_bit) == '0);
			end
			default: begin
				put = 1'b0;
			end
		endcase
	end

	// memory port control
	always_comb begin
		new_row = child_rd;
		new_row[w_sym_q*NODE_W +: NODE_W] = node_count_q + NODE_W'(1);
	end

	always_comb begin
		c_we    = (state_q == S_CLR) || (state_q == S_I_DEC && row_sel == '0 && !node_full);
		c_waddr = (state_q == S_CLR) ? clr_addr_q : insert_node_q;
		c_wdata = (state_q == S_CLR) ? '0 : new_row;
		unique case (state_q)
			S_W_RD:  c_raddr = w_node_q;
			S_B_CUR: c_raddr = q_rd;
			default: c_raddr = insert_node_q;
		endcase

		f_we    = (state_q == S_CLR) || (state_q == S_B_EP3);
		f_waddr = (state_q == S_CLR) ? clr_addr_q : nx_q;
		f_wdata = (state_q == S_CLR) ? '0 : lk_q;
		f_raddr = (state_q == S_B_CUR) ? q_rd : w_node_q;

		e_we = (state_q == S_CLR) || (state_q == S_E_WR) || (state_q == S_B_EP3);
		unique case (state_q)
			S_CLR: begin
				e_waddr = clr_addr_q;
				e_wdata = '0;
			end
			S_E_WR: begin
				e_waddr = insert_node_q;
				e_wdata = end_rd | pc_bit;
			end
			default: begin
				e_waddr = nx_q;
				e_wdata = end_rd | ep_lk_q;
			end
		endcase
		unique case (state_q)
			S_B_EP1: e_raddr = lk_q;
			S_B_EP2: e_raddr = nx_q;
			S_E_RD:  e_raddr = insert_node_q;
			default: e_raddr = match_node_q;
		endcase

		q_we    = (accept && op == mpsm_pkg::OP_BUILD) ||
			(state_q == S_B_EP3 && tail_q < QP_W'(MAX_NODES));
		q_waddr = (state_q == S_IDLE) ? '0 : tail_q[NODE_W-1:0];
		q_wdata = (state_q == S_IDLE) ? '0 : nx_q;

		l_we = (state_q == S_E_WR);
	end

	mpsm_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_child (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(child_rd)
	);

	mpsm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(fail_rd)
	);

	mpsm_ram #(.WIDTH(MAX_PATTERNS), .DEPTH(MAX_NODES)) u_ending (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(end_rd)
	);

	mpsm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(head_q[NODE_W-1:0]), .rdata(q_rd)
	);

	mpsm_ram #(.WIDTH(LEN_W), .DEPTH(MAX_PATTERNS)) u_length (
		.clk(clk), .we(l_we), .waddr(PI_W'(pattern_count_q)), .wdata(insert_len_q),
		.raddr(pi_q), .rdata(len_rd)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLR;
			clr_addr_q      <= '0;
			clr_resp_q      <= 1'b0;
			node_count_q    <= '0;
			pattern_count_q <= '0;
			insert_node_q   <= '0;
			insert_len_q    <= '0;
			match_node_q    <= '0;
			text_pos_q      <= '0;
			status_q        <= mpsm_pkg::ST_OK;
			out_valid_q     <= 1'b0;
		end else begin
			if (put) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					status_q <= mpsm_pkg::ST_OK;
					if (clr_addr_q == NODE_W'(MAX_NODES - 1)) begin
						clr_addr_q <= '0;
						state_q    <= clr_resp_q ? S_RESP : S_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + NODE_W'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						status_q <= mpsm_pkg::ST_OK;
						unique case (op)
							mpsm_pkg::OP_CLEAR: begin
								node_count_q    <= '0;
								pattern_count_q <= '0;
								insert_node_q   <= '0;
								insert_len_q    <= '0;
								match_node_q    <= '0;
								text_pos_q      <= '0;
								clr_addr_q      <= '0;
								clr_resp_q      <= 1'b1;
								state_q         <= S_CLR;
							end
							mpsm_pkg::OP_ADD: begin
								w_sym_q <= sym_idx;
								state_q <= sym_ok ? S_I_RD : S_RESP;
							end
							mpsm_pkg::OP_END: begin
								if (insert_len_q == '0) begin
									status_q      <= mpsm_pkg::ST_EMPTY;
									insert_node_q <= '0;
									state_q       <= S_RESP;
								end else if (pattern_count_q >= PC_W'(MAX_PATTERNS)) begin
									status_q      <= mpsm_pkg::ST_PAT_FULL;
									insert_node_q <= '0;
									insert_len_q  <= '0;
									state_q       <= S_RESP;
								end else begin
									state_q <= S_E_RD;
								end
							end
							mpsm_pkg::OP_BUILD: begin
								head_q  <= '0;
								tail_q  <= QP_W'(1);
								state_q <= S_B_POP;
							end
							mpsm_pkg::OP_TEXT: begin
								pos_q      <= text_pos_q;
								text_pos_q <= text_pos_q + POS_W'(1);
								w_node_q   <= match_node_q;
								w_sym_q    <= sym_idx;
								w_ret_q    <= 1'b0;
								if (sym_ok) begin
									state_q <= S_W_RD;
								end else begin
									match_node_q <= '0;
									state_q      <= S_T_EPRD;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_RESP: begin
					if (can_put) begin
						state_q <= S_IDLE;
					end
				end
				S_I_RD: begin
					state_q <= S_I_DEC;
				end
				S_I_DEC: begin
					if (row_sel == '0) begin
						if (node_full) begin
							status_q <= mpsm_pkg::ST_NODE_FULL;
						end else begin
							node_count_q  <= node_count_q + NODE_W'(1);
							insert_node_q <= node_count_q + NODE_W'(1);
							insert_len_q  <= insert_len_q + LEN_W'(1);
						end
					end else begin
						insert_node_q <= row_sel;
						insert_len_q  <= insert_len_q + LEN_W'(1);
					end
					state_q <= S_RESP;
				end
				S_E_RD: begin
					state_q <= S_E_WR;
				end
				S_E_WR: begin
					pattern_count_q <= pattern_count_q + PC_W'(1);
					insert_node_q   <= '0;
					insert_len_q    <= '0;
					state_q         <= S_RESP;
				end
				S_B_POP: begin
					if (head_q == tail_q) begin
						state_q <= S_RESP;
					end else begin
						head_q  <= head_q + QP_W'(1);
						state_q <= S_B_CUR;
					end
				end
				S_B_CUR: begin
					cur_q   <= q_rd;
					state_q <= S_B_ROW;
				end
				S_B_ROW: begin
					cur_row_q  <= child_rd;
					cur_fail_q <= fail_rd;
					c_q        <= '0;
					state_q    <= S_B_CH;
				end
				S_B_CH: begin
					if (cur_sel != '0) begin
						nx_q <= cur_sel;
						if (cur_q == '0) begin
							lk_q    <= '0;
							state_q <= S_B_EP1;
						end else begin
							w_node_q <= cur_fail_q;
							w_sym_q  <= c_q;
							w_ret_q  <= 1'b1;
							state_q  <= S_W_RD;
						end
					end else if (c_last) begin
						state_q <= S_B_POP;
					end else begin
						c_q <= c_q + SYM_W'(1);
					end
				end
				S_B_EP1: begin
					state_q <= S_B_EP2;
				end
				S_B_EP2: begin
					ep_lk_q <= end_rd;
					state_q <= S_B_EP3;
				end
				S_B_EP3: begin
					if (tail_q < QP_W'(MAX_NODES)) begin
						tail_q <= tail_q + QP_W'(1);
					end
					if (c_last) begin
						state_q <= S_B_POP;
					end else begin
						c_q     <= c_q + SYM_W'(1);
						state_q <= S_B_CH;
					end
				end
				S_W_RD: begin
					state_q <= S_W_CHK;
				end
				S_W_CHK: begin
					if (row_sel != '0 || w_node_q == '0) begin
						if (w_ret_q) begin
							lk_q    <= row_sel;
							state_q <= S_B_EP1;
						end else begin
							match_node_q <= row_sel;
							state_q      <= S_T_EPRD;
						end
					end else begin
						w_node_q <= fail_rd;
						state_q  <= S_W_RD;
					end
				end
				S_T_EPRD: begin
					state_q <= S_T_SET;
				end
				S_T_SET: begin
					ws_q    <= end_rd;
					pi_q    <= '0;
					state_q <= (end_rd == '0) ? S_T_NONE : S_T_SCAN;
				end
				S_T_SCAN: begin
					if (ws_q[pi_q]) begin
						state_q <= S_T_EMIT;
					end else begin
						pi_q <= pi_q + PI_W'(1);
					end
				end
				S_T_EMIT: begin
					if (can_put) begin
						ws_q    <= ws_q & ~pi_bit;
						pi_q    <= pi_q + PI_W'(1);
						state_q <= p_last ? S_IDLE : S_T_SCAN;
					end
				end
				S_T_NONE: begin
					if (can_put) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (put) begin
			match_valid_q    <= p_match;
			pattern_index_q  <= p_idx;
			start_position_q <= p_start;
			status_out_q     <= p_status;
			last_q           <= p_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign match_valid    = match_valid_q;
	assign pattern_index  = pattern_index_q;
	assign start_position = start_position_q;
	assign status         = status_out_q;
	assign last           = last_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("accepted a second transaction while busy");

	a_match_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && match_valid) |-> (status == mpsm_pkg::ST_OK))
		else $error("match result with nonzero status");

	a_pattern_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pattern_count_q <= PC_W'(MAX_PATTERNS))
		else $error("pattern count beyond table size");

	a_insert_depth: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (insert_len_q == '0 || insert_node_q != '0))
		else $error("pattern letters pending at the root node");

endmodule

// ----- rtl/mpsm_ram.sv -----
// ----------------------------------------------------------------------------
// mpsm_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module mpsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = mpsm_pkg::addr_w(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

// ----- verif/tb_multi_pattern_string_matcher.sv -----
// ----------------------------------------------------------------------------
// tb_multi_pattern_string_matcher
// Self-checking testbench for the aho-corasick string matcher. Directed
// dictionaries with known text, a pattern table overflow and a node store
// overflow are followed by random dictionaries and text. A local automaton
// predicts every result, and a monitor compares the results in order.
// ----------------------------------------------------------------------------
module tb_multi_pattern_string_matcher;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ALPHA = 26;
	localparam int NPAT  = 16;
	localparam int NNODE = 1024;
	localparam int IDLE_LIMIT = 400000;

	typedef struct packed {
		logic             mv;
		logic [mpsm_pkg::IDX_W-1:0] idx;
		logic [mpsm_pkg::POS_W-1:0] start;
		logic [mpsm_pkg::STATUS_W-1:0] st;
		logic             lst;
	} match_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [mpsm_pkg::OP_W-1:0] op = mpsm_pkg::OP_CLEAR;
	logic [mpsm_pkg::SYMBOL_W-1:0] symbol = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic match_valid;
	logic [mpsm_pkg::IDX_W-1:0] pattern_index;
	logic [mpsm_pkg::POS_W-1:0] start_position;
	logic [mpsm_pkg::STATUS_W-1:0] status;
	logic last;

	multi_pattern_string_matcher DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .symbol(symbol),
		.out_valid(out_valid), .out_ready(out_ready), .match_valid(match_valid),
		.pattern_index(pattern_index), .start_position(start_position),
		.status(status), .last(last)
	);

	// automaton copy
	logic [9:0]  trie_child [NNODE*ALPHA];
	logic [9:0]  fail_link [NNODE];
	logic [15:0] ends_at [NNODE];
	logic [10:0] pat_len [NPAT];
	int unsigned n_nodes, n_pats, ins_node, ins_len, cur_node;
	logic [31:0] text_pos;

	match_result_t pending_results[$];
	int fail_count = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void clear_automaton();
		foreach (trie_child[i]) trie_child[i] = '0;
		foreach (fail_link[i]) fail_link[i] = '0;
		foreach (ends_at[i]) ends_at[i] = '0;
		n_nodes = 0;
		n_pats = 0;
		ins_node = 0;
		ins_len = 0;
		cur_node = 0;
		text_pos = '0;
	endfunction

	function automatic int unsigned goto_state(int unsigned node, int unsigned sym);
		int unsigned nx;
		if (sym >= ALPHA)
			return 0;
		for (int s = 0; s < NNODE; s++) begin
			nx = trie_child[node*ALPHA + sym];
			if (nx != 0)
				return nx;
			if (node == 0)
				return 0;
			node = fail_link[node];
		end
		return 0;
	endfunction

	function automatic void build_fail_links();
		int unsigned bfs[$];
		int unsigned cur, nx, lk;
		bfs.push_back(0);
		while (bfs.size() > 0) begin
			cur = bfs.pop_front();
			for (int c = 0; c < ALPHA; c++) begin
				nx = trie_child[cur*ALPHA + c];
				if (nx == 0)
					continue;
				lk = (cur == 0) ? 0 : goto_state(fail_link[cur], c);
				fail_link[nx] = lk;
				ends_at[nx] |= ends_at[lk];
				bfs.push_back(nx);
			end
		end
	endfunction

	function automatic void predict_transaction(logic [mpsm_pkg::OP_W-1:0] o,
			logic [mpsm_pkg::SYMBOL_W-1:0] s);
		logic [mpsm_pkg::STATUS_W-1:0] st;
		match_result_t r;
		int unsigned slot, n;
		logic [31:0] pos;
		st = mpsm_pkg::ST_OK;
		n = 0;
		case (o)
			mpsm_pkg::OP_CLEAR: clear_automaton();
			mpsm_pkg::OP_ADD: begin
				if (s < ALPHA) begin
					slot = ins_node*ALPHA + s;
					if (trie_child[slot] == 0) begin
						if (n_nodes + 1 >= NNODE)
							st = mpsm_pkg::ST_NODE_FULL;
						else begin
							n_nodes++;
							trie_child[slot] = n_nodes;
						end
					end
					if (st == mpsm_pkg::ST_OK) begin
						ins_node = trie_child[slot];
						ins_len++;
					end
				end
			end
			mpsm_pkg::OP_END: begin
				if (ins_len == 0)
					st = mpsm_pkg::ST_EMPTY;
				else if (n_pats >= NPAT)
					st = mpsm_pkg::ST_PAT_FULL;
				else begin
					pat_len[n_pats] = ins_len;
					ends_at[ins_node][n_pats] = 1'b1;
					n_pats++;
				end
				ins_node = 0;
				ins_len = 0;
			end
			mpsm_pkg::OP_BUILD: build_fail_links();
			mpsm_pkg::OP_TEXT: begin
				pos = text_pos;
				cur_node = goto_state(cur_node, s);
				text_pos = pos + 1;
				for (int i = 0; i < n_pats; i++) begin
					if (ends_at[cur_node][i]) begin
						r = '{1'b1, i[mpsm_pkg::IDX_W-1:0], pos - 32'(pat_len[i]) + 32'd1,
							mpsm_pkg::ST_OK, 1'b0};
						pending_results.push_back(r);
						n++;
					end
				end
				if (n > 0) begin
					pending_results[pending_results.size()-1].lst = 1'b1;
					return;
				end
			end
			default: ;
		endcase
		r = '{1'b0, '0, '0, st, 1'b1};
		pending_results.push_back(r);
	endfunction

	// one transaction on the input channel, with bursts and gaps
	task automatic send_item(logic [mpsm_pkg::OP_W-1:0] o, logic [mpsm_pkg::SYMBOL_W-1:0] s);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		op <= o;
		symbol <= s;
		do @(posedge clk); while (!in_ready);
		predict_transaction(o, s);
	endtask

	task automatic send_word(logic [4:0] w[$]);
		foreach (w[i]) send_item(mpsm_pkg::OP_ADD, w[i]);
		send_item(mpsm_pkg::OP_END, '0);
	endtask

	// output ready pattern
	int stall_seg = 0;
	int stall_mode = 0;
	always @(posedge clk) begin
		if (stall_seg == 0) begin
			stall_seg = $urandom_range(10, 60);
			stall_mode = $urandom_range(0, 2);
		end
		stall_seg--;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= (stall_seg % 5) != 0;
		endcase
	end

	// result checker
	always @(posedge clk) begin
		match_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected transaction on output");
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				if (match_valid !== e.mv) begin
					$error("match_valid exp %0d got %0d", e.mv, match_valid);
					fail_count++;
				end
				if (pattern_index !== e.idx) begin
					$error("pattern_index exp %0d got %0d", e.idx, pattern_index);
					fail_count++;
				end
				if (start_position !== e.start) begin
					$error("start_position exp %0d got %0d", e.start, start_position);
					fail_count++;
				end
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status);
					fail_count++;
				end
				if (last !== e.lst) begin
					$error("last exp %0d got %0d", e.lst, last);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic test_directed();
		logic [4:0] txt[8];
		txt = '{5'd20, 5'd18, 5'd7, 5'd4, 5'd27, 5'd18, 5'd7, 5'd4};
		send_item(mpsm_pkg::OP_TEXT, 5'd7);
		send_word({5'd7, 5'd4});
		send_word({5'd18, 5'd7, 5'd4});
		send_item(mpsm_pkg::OP_ADD, 5'd31);
		send_word({5'd7, 5'd8, 5'd18});
		send_item(mpsm_pkg::OP_END, '0);
		send_item(mpsm_pkg::OP_TEXT, 5'd18);
		send_item(mpsm_pkg::OP_BUILD, '0);
		foreach (txt[i])
			send_item(mpsm_pkg::OP_TEXT, txt[i]);
		send_item(3'd5, 5'd0);
		send_item(3'd6, 5'd25);
		send_item(3'd7, 5'd31);
		send_item(mpsm_pkg::OP_CLEAR, '0);
	endtask

	task automatic test_pattern_table_full();
		send_item(mpsm_pkg::OP_CLEAR, '0);
		for (int p = 0; p <= NPAT; p++)
			send_word({5'(p % ALPHA), 5'd25});
		send_item(mpsm_pkg::OP_BUILD, '0);
		for (int i = 0; i < 12; i++)
			send_item(mpsm_pkg::OP_TEXT,
				$urandom_range(0, 1) ? 5'd25 : 5'($urandom_range(0, 16)));
	endtask

	task automatic test_node_store_full();
		send_item(mpsm_pkg::OP_CLEAR, '0);
		for (int i = 0; i < NNODE + 1; i++)
			send_item(mpsm_pkg::OP_ADD, 5'($urandom_range(0, 2)));
		send_item(mpsm_pkg::OP_END, '0);
		send_word({5'd0});
		send_item(mpsm_pkg::OP_BUILD, '0);
		for (int i = 0; i < 10; i++)
			send_item(mpsm_pkg::OP_TEXT, 5'($urandom_range(0, 2)));
		send_item(mpsm_pkg::OP_CLEAR, '0);
	endtask

	task automatic test_random_text();
		int sent;
		int npat, len, alpha_hi;
		logic [4:0] w[$];
		sent = 0;
		while (sent < 270) begin
			if ($urandom_range(0, 2) == 0) begin
				send_item(mpsm_pkg::OP_CLEAR, '0);
				sent++;
			end
			alpha_hi = $urandom_range(0, 3) == 0 ? 25 : 3;
			npat = $urandom_range(1, 6);
			for (int p = 0; p < npat; p++) begin
				w = {};
				len = $urandom_range(1, 4);
				for (int k = 0; k < len; k++)
					w.push_back(5'($urandom_range(0, alpha_hi)));
				send_word(w);
				sent += len + 1;
			end
			send_item(mpsm_pkg::OP_BUILD, '0);
			for (int t = $urandom_range(10, 40); t > 0; t--) begin
				case ($urandom_range(0, 19))
					0: send_item(mpsm_pkg::OP_TEXT, 5'($urandom_range(26, 31)));
					1: send_item(3'($urandom_range(5, 7)), 5'($urandom));
					2: send_item(mpsm_pkg::OP_END, '0);
					default: send_item(mpsm_pkg::OP_TEXT, 5'($urandom_range(0, alpha_hi)));
				endcase
				sent++;
			end
		end
	endtask

	initial begin
		clear_automaton();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_pattern_table_full();
		test_node_store_full();
		test_random_text();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
